// ===== rtl/bdar_pkg.sv =====
`default_nettype none

package bdar_pkg;

	localparam int NUM_BUTTONS = 2;
	localparam int IDX_W = 1;
	localparam int DELAY_W = 8;

	localparam logic [DELAY_W-1:0] INITIAL_DELAY_RESET = 8'd100;
	localparam logic [DELAY_W-1:0] REPEAT_DELAY_RESET = 8'd10;

	localparam logic LEVEL_PRESSED = 1'b0;
	localparam logic LEVEL_RELEASED = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam int REG_SEL_W = 1;
	localparam logic [REG_SEL_W-1:0] REG_INITIAL_DELAY = 1'b0;
	localparam logic [REG_SEL_W-1:0] REG_REPEAT_DELAY = 1'b1;

	typedef struct packed {
		logic command;
		logic [NUM_BUTTONS-1:0] pin_levels;
		logic [IDX_W-1:0] button_index;
	} req_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] pressed_flags;
		logic step_event;
	} rsp_t;

	typedef struct packed {
		logic sample;
		logic poll;
		logic level;
	} cell_ctl_t;

	typedef struct packed {
		logic [DELAY_W-1:0] initial_delay;
		logic [DELAY_W-1:0] repeat_delay;
	} delays_t;

endpackage

`default_nettype wire

// ===== rtl/bdar_button.sv =====
`default_nettype none

module bdar_button (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bdar_pkg::cell_ctl_t ctl,
	input  wire bdar_pkg::delays_t   delays,
	output logic                     pressed_next,
	output logic                     step_event
);

	logic                         newer_q;
	logic                         older_q;
	logic                         stable_q;
	logic                         flag_q;
	logic [bdar_pkg::DELAY_W-1:0] count_q;

	logic                         stable_d;
	logic                         flag_d;
	logic [bdar_pkg::DELAY_W-1:0] count_d;
	logic                         agree;
	logic                         held;

	assign agree = (ctl.level == newer_q);
	assign held = (stable_q == bdar_pkg::LEVEL_PRESSED);

	always_comb begin
		stable_d = stable_q;
		flag_d = flag_q;
		count_d = count_q;
		step_event = 1'b0;
		if (ctl.sample && agree) begin
			if (stable_q != ctl.level) begin
				stable_d = ctl.level;
				if (ctl.level == bdar_pkg::LEVEL_PRESSED) begin
					flag_d = 1'b1;
					count_d = delays.initial_delay;
				end
			end else if (held && count_q != '0) begin
				count_d = count_q - {{(bdar_pkg::DELAY_W-1){1'b0}}, 1'b1};
			end
		end else if (ctl.poll) begin
			if (flag_q) begin
				flag_d = 1'b0;
				step_event = 1'b1;
			end else if (held && count_q == '0) begin
				count_d = delays.repeat_delay;
				step_event = 1'b1;
			end
		end
	end

	assign pressed_next = (stable_d == bdar_pkg::LEVEL_PRESSED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newer_q <= bdar_pkg::LEVEL_RELEASED;
			older_q <= bdar_pkg::LEVEL_RELEASED;
			stable_q <= bdar_pkg::LEVEL_RELEASED;
			flag_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (ctl.sample) begin
				older_q <= newer_q;
				newer_q <= ctl.level;
			end
			stable_q <= stable_d;
			flag_q <= flag_d;
			count_q <= count_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sample && !ctl.poll |-> !step_event)
		else $error("step event on a sample");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sample |=> older_q == $past(newer_q))
		else $error("sample history did not shift");

	assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.sample && !ctl.poll |=> $stable(stable_q) && $stable(count_q) && $stable(flag_q))
		else $error("button state changed without a request");

endmodule

`default_nettype wire

// ===== rtl/button_debounce_auto_repeat_core.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data   (bdar_pkg::req_t)
// out       output     out_valid / out_ready  out_data  (bdar_pkg::rsp_t)
// config    APB        psel / penable / pready  paddr, pwdata, prdata
//
// One request per cycle while the result register is not stalled.
// The input register and the result register form a two-stage pipeline; the
// per-button state updates as a request moves into the result register.
// A stalled result holds the pipeline; in_ready drops only when both stages are full.
// Reset releases all buttons, clears press flags and hold counters, and loads
// the delay registers with 100 and 10.

module button_debounce_auto_repeat_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire bdar_pkg::req_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output bdar_pkg::rsp_t        out_data,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	bdar_pkg::delays_t delays_q;
	logic              cfg_write;
	logic [bdar_pkg::REG_SEL_W-1:0] reg_sel;

	logic              valid_s1;
	bdar_pkg::req_t    req_s1;
	logic              advance;

	logic              out_valid_q;
	bdar_pkg::rsp_t    out_data_q;
	bdar_pkg::rsp_t    result;

	logic [bdar_pkg::NUM_BUTTONS-1:0] pressed_next;
	logic [bdar_pkg::NUM_BUTTONS-1:0] events;

	assign pready = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delays_q.initial_delay <= bdar_pkg::INITIAL_DELAY_RESET;
			delays_q.repeat_delay <= bdar_pkg::REPEAT_DELAY_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				bdar_pkg::REG_INITIAL_DELAY: delays_q.initial_delay <= pwdata[7:0];
				bdar_pkg::REG_REPEAT_DELAY: delays_q.repeat_delay <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			bdar_pkg::REG_INITIAL_DELAY: prdata = {24'd0, delays_q.initial_delay};
			bdar_pkg::REG_REPEAT_DELAY: prdata = {24'd0, delays_q.repeat_delay};
			default: prdata = '0;
		endcase
	end

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
	end

	for (genvar b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin : g_button
		bdar_pkg::cell_ctl_t ctl;

		assign ctl.sample = advance && (req_s1.command == bdar_pkg::CMD_SAMPLE);
		assign ctl.poll = advance && (req_s1.command == bdar_pkg::CMD_POLL)
			&& (req_s1.button_index == (bdar_pkg::IDX_W)'(b));
		assign ctl.level = req_s1.pin_levels[b];

		bdar_button u_button (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.delays       (delays_q),
			.pressed_next (pressed_next[b]),
			.step_event   (events[b])
		);
	end

	assign result.pressed_flags = pressed_next;
	assign result.step_event = |events;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("request taken into a blocked pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.command == bdar_pkg::CMD_SAMPLE |=> !out_data_q.step_event)
		else $error("step event reported for a sample");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && reg_sel == bdar_pkg::REG_REPEAT_DELAY
		|=> delays_q.repeat_delay == $past(pwdata[7:0]))
		else $error("repeat delay write lost");

endmodule

`default_nettype wire

// ===== dv/tb_button_debounce_auto_repeat_core.sv =====
`timescale 1ns / 1ps

module tb_button_debounce_auto_repeat_core;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	bdar_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bdar_pkg::rsp_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	button_debounce_auto_repeat_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	bdar_pkg::req_t pending_requests[$];
	bdar_pkg::rsp_t expected_status[$];
	int fail_count = 0;
	bit idle_on = 1'b1;
	int gap_left = 0;
	int stall_left = 0;

	logic [bdar_pkg::DELAY_W-1:0] cfg_initial_delay;
	logic [bdar_pkg::DELAY_W-1:0] cfg_repeat_delay;
	logic newer_lvl [bdar_pkg::NUM_BUTTONS];
	logic older_lvl [bdar_pkg::NUM_BUTTONS];
	logic stable_lvl [bdar_pkg::NUM_BUTTONS];
	logic first_press [bdar_pkg::NUM_BUTTONS];
	logic [bdar_pkg::DELAY_W-1:0] hold_cnt [bdar_pkg::NUM_BUTTONS];

	function automatic bdar_pkg::rsp_t debounce_step(bdar_pkg::req_t req);
		bdar_pkg::rsp_t rsp;
		int b;
		rsp = '0;
		if (req.command == bdar_pkg::CMD_SAMPLE) begin
			for (b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
				older_lvl[b] = newer_lvl[b];
				newer_lvl[b] = req.pin_levels[b];
				if (newer_lvl[b] == older_lvl[b]) begin
					if (stable_lvl[b] != newer_lvl[b]) begin
						stable_lvl[b] = newer_lvl[b];
						if (stable_lvl[b] == bdar_pkg::LEVEL_PRESSED) begin
							first_press[b] = 1'b1;
							hold_cnt[b] = cfg_initial_delay;
						end
					end else if (stable_lvl[b] == bdar_pkg::LEVEL_PRESSED
						&& hold_cnt[b] != 0) begin
						hold_cnt[b] = hold_cnt[b] - 1'b1;
					end
				end
			end
		end else if (int'(req.button_index) < bdar_pkg::NUM_BUTTONS) begin
			b = int'(req.button_index);
			if (first_press[b]) begin
				first_press[b] = 1'b0;
				rsp.step_event = 1'b1;
			end else if (stable_lvl[b] == bdar_pkg::LEVEL_PRESSED && hold_cnt[b] == 0) begin
				hold_cnt[b] = cfg_repeat_delay;
				rsp.step_event = 1'b1;
			end
		end
		for (b = 0; b < bdar_pkg::NUM_BUTTONS; b++)
			rsp.pressed_flags[b] = (stable_lvl[b] == bdar_pkg::LEVEL_PRESSED);
		return rsp;
	endfunction

	initial begin
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_status.push_back(debounce_step(in_data));
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				in_data <= pending_requests.pop_front();
				in_valid <= 1'b1;
				gap_left <= idle_on ? $urandom_range(0, 12) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : monitor
		bdar_pkg::rsp_t want;
		int n;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					$error("result with no request waiting: %b", out_data);
					fail_count++;
				end else begin
					want = expected_status.pop_front();
					if (out_data.pressed_flags !== want.pressed_flags) begin
						$error("pressed_flags: expected %b, got %b",
							want.pressed_flags, out_data.pressed_flags);
						fail_count++;
					end
					if (out_data.step_event !== want.step_event) begin
						$error("step_event: expected %b, got %b",
							want.step_event, out_data.step_event);
						fail_count++;
					end
				end
				n = idle_on ? $urandom_range(0, 12) : 0;
				out_ready <= (n == 0);
				stall_left <= n;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= (stall_left == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_sample(logic [bdar_pkg::NUM_BUTTONS-1:0] pins);
		bdar_pkg::req_t req;
		req = '0;
		req.command = bdar_pkg::CMD_SAMPLE;
		req.pin_levels = pins;
		req.button_index = (bdar_pkg::IDX_W)'($urandom_range(0, 1));
		pending_requests.push_back(req);
	endtask

	task automatic push_poll(logic [bdar_pkg::IDX_W-1:0] idx);
		bdar_pkg::req_t req;
		req = '0;
		req.command = bdar_pkg::CMD_POLL;
		req.pin_levels = (bdar_pkg::NUM_BUTTONS)'($urandom_range(0, 3));
		req.button_index = idx;
		pending_requests.push_back(req);
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || expected_status.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [bdar_pkg::REG_SEL_W-1:0] sel,
		logic [bdar_pkg::DELAY_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'({sel, 2'b00});
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (sel)
			bdar_pkg::REG_INITIAL_DELAY: cfg_initial_delay = val;
			bdar_pkg::REG_REPEAT_DELAY: cfg_repeat_delay = val;
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(logic [bdar_pkg::REG_SEL_W-1:0] sel,
		logic [bdar_pkg::DELAY_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'({sel, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[bdar_pkg::DELAY_W-1:0] !== want) begin
			$error("prdata: expected %0d, got %0d", want, prdata[bdar_pkg::DELAY_W-1:0]);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_delays(logic [bdar_pkg::DELAY_W-1:0] first,
		logic [bdar_pkg::DELAY_W-1:0] again);
		wait_drained();
		reg_write(bdar_pkg::REG_INITIAL_DELAY, first);
		reg_write(bdar_pkg::REG_REPEAT_DELAY, again);
		reg_read(bdar_pkg::REG_INITIAL_DELAY, first);
		reg_read(bdar_pkg::REG_REPEAT_DELAY, again);
	endtask

	task automatic push_random(int n);
		int count;
		int kind;
		int len;
		logic [bdar_pkg::NUM_BUTTONS-1:0] level;
		count = 0;
		while (count < n) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				level = (bdar_pkg::NUM_BUTTONS)'($urandom_range(0, 3));
				len = $urandom_range(2, 10);
				repeat (len) begin
					push_sample(level);
					count++;
					if ($urandom_range(0, 1) == 1) begin
						push_poll((bdar_pkg::IDX_W)'($urandom_range(0, 1)));
						count++;
					end
				end
			end else if (kind < 9) begin
				len = $urandom_range(1, 4);
				repeat (len) begin
					push_poll((bdar_pkg::IDX_W)'($urandom_range(0, 1)));
					count++;
				end
			end else begin
				len = $urandom_range(1, 3);
				repeat (len) begin
					push_sample((bdar_pkg::NUM_BUTTONS)'($urandom_range(0, 3)));
					count++;
				end
			end
		end
	endtask

	initial begin
		cfg_initial_delay = bdar_pkg::INITIAL_DELAY_RESET;
		cfg_repeat_delay = bdar_pkg::REPEAT_DELAY_RESET;
		for (int b = 0; b < bdar_pkg::NUM_BUTTONS; b++) begin
			newer_lvl[b] = bdar_pkg::LEVEL_RELEASED;
			older_lvl[b] = bdar_pkg::LEVEL_RELEASED;
			stable_lvl[b] = bdar_pkg::LEVEL_RELEASED;
			first_press[b] = 1'b0;
			hold_cnt[b] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_read(bdar_pkg::REG_INITIAL_DELAY, bdar_pkg::INITIAL_DELAY_RESET);
		reg_read(bdar_pkg::REG_REPEAT_DELAY, bdar_pkg::REPEAT_DELAY_RESET);

		// reset delays: glitches, double press, release with a pending press
		push_poll(1'b0);
		push_poll(1'b1);
		push_sample(2'b10);
		push_sample(2'b11);
		push_sample(2'b00);
		push_sample(2'b00);
		push_poll(1'b0);
		push_poll(1'b1);
		push_poll(1'b0);
		push_sample(2'b11);
		push_sample(2'b11);
		push_sample(2'b01);
		push_sample(2'b01);
		push_sample(2'b11);
		push_sample(2'b11);
		push_poll(1'b1);
		push_poll(1'b1);

		// zero delays: flag first, then an immediate repeat
		set_delays('0, '0);
		push_sample(2'b00);
		push_sample(2'b00);
		push_poll(1'b0);
		push_poll(1'b0);
		push_poll(1'b0);
		push_sample(2'b00);
		push_poll(1'b1);
		push_poll(1'b1);
		push_poll(1'b1);
		push_sample(2'b11);
		push_sample(2'b11);

		set_delays('1, '1);
		push_sample(2'b10);
		push_sample(2'b10);
		push_poll(1'b0);
		repeat (10) push_sample(2'b10);
		push_poll(1'b0);
		push_poll(1'b1);
		push_random(40);

		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 2)
				set_delays((bdar_pkg::DELAY_W)'($urandom_range(0, 255)),
					(bdar_pkg::DELAY_W)'($urandom_range(0, 255)));
			else
				set_delays((bdar_pkg::DELAY_W)'($urandom_range(0, 6)),
					(bdar_pkg::DELAY_W)'($urandom_range(0, 4)));
			idle_on = (phase != 3);
			push_random(100);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_status.size() == 0)
			$display("PASS button_debounce_auto_repeat_core");
		else
			$display("FAIL button_debounce_auto_repeat_core");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL button_debounce_auto_repeat_core");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bdar_pkg.sv
rtl/bdar_button.sv
rtl/button_debounce_auto_repeat_core.sv
dv/tb_button_debounce_auto_repeat_core.sv
